### src/key_scan_event_fifo_macros.svh
// Assertion helpers for the key scan event queue.
`ifndef KEY_SCAN_EVENT_FIFO_MACROS_SVH
`define KEY_SCAN_EVENT_FIFO_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst is high.
`define KSEF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("key scan event queue check failed");
// Next-cycle implication, sampled on clk, off while rst is high.
`define KSEF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("key scan event queue check failed");
`else
`define KSEF_ASSERT_NOW(label, ante, cons)
`define KSEF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### src/ksef_pkg.sv
package ksef_pkg;

  // event kinds
  localparam logic [1:0] EV_UP   = 2'd0;
  localparam logic [1:0] EV_DOWN = 2'd1;
  localparam logic [1:0] EV_HOLD = 2'd2;

  // queue occupancy codes
  localparam logic [1:0] QS_EMPTY  = 2'd0;
  localparam logic [1:0] QS_NORMAL = 2'd1;
  localparam logic [1:0] QS_FULL   = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 2'd1;

  localparam logic [7:0] PRESS_TICKS_RST = 8'd2;
  localparam logic [7:0] HOLD_TICKS_RST  = 8'd100;

  // keys that have a level bit on the input
  localparam int unsigned LEVEL_W = 4;

  typedef struct packed {
    logic [1:0] key;
    logic [1:0] status;
  } ksef_event_t;

  typedef struct packed {
    logic capture;    // latch the request
    logic scan_step;  // process one key
    logic pop;        // pop one event
    logic load_out;   // load the result register
  } ksef_cmd_t;

  typedef struct packed {
    logic is_pop;
    logic last_key;
    logic out_free;
  } ksef_status_t;

endpackage

### src/ksef_queue.sv
module ksef_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ksef_pkg::ksef_event_t push_ev,
  input  logic                pop,
  output ksef_pkg::ksef_event_t rd_ev,
  output logic                rd_hit,
  output logic                empty,
  output logic                full
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ksef_pkg::ksef_event_t mem [DEPTH];

  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [1:0]    q_state;
  logic [PW-1:0] wptr_next;
  logic [PW-1:0] rptr_next;
  logic          do_push;
  logic          do_pop;

  assign empty = (q_state == ksef_pkg::QS_EMPTY);
  assign full  = (q_state == ksef_pkg::QS_FULL);

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  assign wptr_next = (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
  assign rptr_next = (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_ev;
    end
    if (do_pop) begin
      rd_ev <= mem[rptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr    <= '0;
      rptr    <= '0;
      q_state <= ksef_pkg::QS_EMPTY;
      rd_hit  <= 1'b0;
    end else begin
      if (pop) begin
        rd_hit <= do_pop;
      end
      if (do_push) begin
        wptr    <= wptr_next;
        q_state <= (wptr_next == rptr) ? ksef_pkg::QS_FULL : ksef_pkg::QS_NORMAL;
      end else if (do_pop) begin
        rptr    <= rptr_next;
        q_state <= (rptr_next == wptr) ? ksef_pkg::QS_EMPTY : ksef_pkg::QS_NORMAL;
      end
    end
  end

endmodule

### src/ksef_ctrl.sv
module ksef_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  ksef_pkg::ksef_status_t stat,
  output ksef_pkg::ksef_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WORK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_WORK;
        end
      end
      ST_WORK: begin
        if (stat.is_pop) begin
          cmd.pop    = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.scan_step = 1'b1;
          if (stat.last_key) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // hold until the result register can take the answer
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/ksef_dp.sv
module ksef_dp #(
  parameter int unsigned NUM_KEYS    = 4,
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ksef_pkg::ksef_cmd_t              cmd,
  output ksef_pkg::ksef_status_t           stat,
  input  logic                             s_tuser,
  input  logic [7:0]                       s_tdata,
  input  logic                             cfg_we,
  input  logic [ksef_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                       cfg_data,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [7:0]                       m_tdata,
  output logic [1:0]                       m_tuser
);

  localparam int unsigned KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [7:0] press_ticks;
  logic [7:0] hold_ticks;
  logic       op_pop;
  logic [ksef_pkg::LEVEL_W-1:0] levels;
  logic [KW-1:0] idx;
  logic [7:0] cnt [NUM_KEYS];

  logic       msg_valid;
  logic [1:0] msg_key;
  logic [1:0] msg_status;
  logic       fifo_empty;
  logic       fifo_full;

  logic [4:0] idx_w;
  logic       pressed;
  logic [7:0] cnt_cur;
  logic [7:0] cnt_inc;
  logic [7:0] cnt_new;
  logic [8:0] down_mark;
  logic [8:0] hold_mark;
  logic       push_ev;
  logic [1:0] ev_status;
  logic       last_key;

  ksef_pkg::ksef_event_t q_wr_ev;
  ksef_pkg::ksef_event_t q_rd_ev;
  logic                  q_rd_hit;
  logic                  q_empty;
  logic                  q_full;

  assign last_key = (idx == KW'(NUM_KEYS - 1));

  assign stat.is_pop   = op_pop;
  assign stat.last_key = last_key;
  assign stat.out_free = !m_tvalid || m_tready;

  // keys past the level bits read as released
  assign idx_w   = 5'(idx);
  assign pressed = (idx_w < 5'(ksef_pkg::LEVEL_W)) && levels[idx_w[1:0]];

  assign cnt_cur   = cnt[idx];
  assign cnt_inc   = cnt_cur + 8'd1;
  assign down_mark = {1'b0, press_ticks} + 9'd1;
  assign hold_mark = {1'b0, hold_ticks} + 9'd1;

  always_comb begin
    cnt_new   = cnt_inc;
    push_ev   = 1'b0;
    ev_status = ksef_pkg::EV_UP;
    if (pressed) begin
      priority if (cnt_inc <= press_ticks) begin
        cnt_new = cnt_inc;
      end else if ({1'b0, cnt_inc} == down_mark) begin
        push_ev   = 1'b1;
        ev_status = ksef_pkg::EV_DOWN;
      end else if (cnt_inc <= hold_ticks) begin
        cnt_new = cnt_inc;
      end else if ({1'b0, cnt_inc} == hold_mark) begin
        push_ev   = 1'b1;
        ev_status = ksef_pkg::EV_HOLD;
        cnt_new   = down_mark[7:0];
      end else begin
        cnt_new = down_mark[7:0];
      end
    end else begin
      cnt_new = 8'd0;
      if (cnt_cur > press_ticks) begin
        push_ev   = 1'b1;
        ev_status = ksef_pkg::EV_UP;
      end
    end
  end

  assign q_wr_ev.key    = idx_w[1:0];
  assign q_wr_ev.status = ev_status;

  ksef_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (cmd.scan_step && push_ev),
    .push_ev(q_wr_ev),
    .pop    (cmd.pop),
    .rd_ev  (q_rd_ev),
    .rd_hit (q_rd_hit),
    .empty  (q_empty),
    .full   (q_full)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      press_ticks <= ksef_pkg::PRESS_TICKS_RST;
      hold_ticks  <= ksef_pkg::HOLD_TICKS_RST;
      op_pop      <= 1'b0;
      idx         <= '0;
      m_tvalid    <= 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        cnt[k] <= 8'd0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == ksef_pkg::REG_PRESS_TICKS) begin
          press_ticks <= cfg_data;
        end else if (cfg_index == ksef_pkg::REG_HOLD_TICKS) begin
          hold_ticks <= cfg_data;
        end
      end
      if (cmd.capture) begin
        op_pop <= s_tuser;
        idx    <= '0;
      end else if (cmd.scan_step) begin
        cnt[idx] <= cnt_new;
        idx      <= last_key ? '0 : idx + 1'b1;
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      levels <= s_tdata[ksef_pkg::LEVEL_W-1:0];
    end
    if (cmd.load_out) begin
      msg_valid  <= op_pop && q_rd_hit;
      msg_key    <= (op_pop && q_rd_hit) ? q_rd_ev.key : 2'd0;
      msg_status <= (op_pop && q_rd_hit) ? q_rd_ev.status : 2'd0;
      fifo_empty <= q_empty;
      fifo_full  <= q_full;
    end
  end

  assign m_tdata = {3'b000, fifo_full, fifo_empty, msg_key, msg_valid};
  assign m_tuser = msg_status;

endmodule

### src/key_scan_event_fifo.sv
// Key scanner with press / hold / release event queue.
// Tick request: after accept, each key is scanned in turn, then the result register is loaded.
// Pop request: after accept, the queue is read, then the result register is loaded (queue memory read is registered).
// One request at a time: a new request is taken only after the last result is loaded;
// a stalled result holds the block until the output register frees up.
// Synchronous active-high reset clears counters, queue pointers and config to defaults.
`include "key_scan_event_fifo_macros.svh"

module key_scan_event_fifo #(
  parameter int unsigned NUM_KEYS    = 4,
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [3:0] key_levels, [7:4] zero
  input  logic                           s_tuser,   // [0] operation
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [0] msg_valid, [2:1] msg_key,
                                                    // [3] fifo_empty, [4] fifo_full,
                                                    // [7:5] zero
  output logic [1:0]                     m_tuser,   // [1:0] msg_status
  input  logic                           cfg_we,
  input  logic [ksef_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  ksef_pkg::ksef_cmd_t    cmd;
  ksef_pkg::ksef_status_t stat;

  ksef_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  ksef_dp #(
    .NUM_KEYS   (NUM_KEYS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // a request keeps the block busy in the cycle after it is accepted
  `KSEF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  // the queue is never reported empty and full at once
  `KSEF_ASSERT_NOW(a_empty_full_excl, m_tvalid, !(m_tdata[3] && m_tdata[4]))
  // a returned event carries a real kind; other results carry none
  `KSEF_ASSERT_NOW(a_status_code, m_tvalid, m_tdata[0] ? (m_tuser != 2'd3) : (m_tuser == 2'd0))

endmodule
